FILE: hdl/plc_read_response_deframer_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef PLC_READ_RESPONSE_DEFRAMER_DEFINES_SVH
`define PLC_READ_RESPONSE_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

`define PRD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

`define PRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define PRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define PRD_ASSERT(lbl, clk, rstn, prop)
`define PRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/prd_pkg.sv
package prd_pkg;

  localparam int MaxItems  = 32;
  localparam int LenBits   = 16;
  localparam int IdxBits   = $clog2(MaxItems);
  localparam int CountBits = $clog2(MaxItems + 1);

  localparam int FifoDepth    = 4;
  localparam int FifoPtrBits  = $clog2(FifoDepth);
  localparam int FifoCntBits  = $clog2(FifoDepth + 1);

  localparam logic [15:0] HdrPos   = 16'd20;
  localparam logic [7:0]  MarkerHi = 8'hFF;
  localparam logic [7:0]  MarkerLo = 8'h04;
  localparam logic [7:0]  RangeHi  = 8'h05;
  localparam logic [7:0]  RangeLo  = 8'h00;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_ERR   = 2'd1,
    ST_RANGE_ERR = 2'd2,
    ST_TOO_MANY  = 2'd3
  } prd_status_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  resp_byte;
    logic [15:0] item_len;
    logic        new_list;
    logic        frame_end;
  } prd_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_out;
    logic [4:0]  item_index;
    logic [1:0]  status;
    logic        last;
  } prd_result_t;

  // Up to two results per byte, in order: res[0] first.
  typedef struct packed {
    logic [1:0]             num;
    prd_result_t [1:0]      res;
  } prd_push_t;

endpackage

FILE: hdl/prd_in_if.sv
interface prd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  resp_byte;
  logic [15:0] item_len;
  logic        new_list;
  logic        frame_end;

  modport source (output valid, cmd, resp_byte, item_len, new_list, frame_end,
                  input ready);
  modport sink   (input valid, cmd, resp_byte, item_len, new_list, frame_end,
                  output ready);
endinterface

FILE: hdl/prd_out_if.sv
interface prd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_out;
  logic [4:0] item_index;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, data_out, item_index, status, last,
                  input ready);
  modport sink   (input valid, kind, data_out, item_index, status, last,
                  output ready);
endinterface

FILE: hdl/prd_result_fifo.sv
`include "plc_read_response_deframer_defines.svh"

module prd_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prd_pkg::prd_push_t  push_i,
  output logic                room_o,
  prd_out_if.source           out_o
);

  prd_pkg::prd_result_t [prd_pkg::FifoDepth-1:0] mem_q;

  logic [prd_pkg::FifoPtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [prd_pkg::FifoCntBits-1:0] cnt_q, cnt_d;
  logic                            pop;
  prd_pkg::prd_result_t            head;

  // Room for a full pair of results, so the parser never has to split a byte.
  assign room_o = (cnt_q <= prd_pkg::FifoCntBits'(prd_pkg::FifoDepth - 2));

  assign head            = mem_q[rd_ptr_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.kind       = head.kind;
  assign out_o.data_out   = head.data_out;
  assign out_o.item_index = head.item_index;
  assign out_o.status     = head.status;
  assign out_o.last       = head.last;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q + prd_pkg::FifoPtrBits'(push_i.num);
    rd_ptr_d = rd_ptr_q + prd_pkg::FifoPtrBits'(pop);
    cnt_d    = cnt_q + prd_pkg::FifoCntBits'(push_i.num)
             - prd_pkg::FifoCntBits'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + prd_pkg::FifoPtrBits'(1)] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `PRD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= prd_pkg::FifoCntBits'(prd_pkg::FifoDepth))
  `PRD_ASSERT(a_no_overflow, clk_i, rst_ni, int'(cnt_q) + int'(push_i.num) <= prd_pkg::FifoDepth)
  `PRD_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid)

endmodule

FILE: hdl/prd_parser.sv
`include "plc_read_response_deframer_defines.svh"

module prd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  prd_in_if.sink              in_i,
  input  logic                room_i,
  output prd_pkg::prd_push_t  push_o
);

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  logic                 vld_q;
  prd_pkg::prd_item_t   item_q;

  logic [prd_pkg::LenBits-1:0] table_q [prd_pkg::MaxItems];

  logic [prd_pkg::CountBits-1:0] list_cnt_q, list_cnt_d;
  logic [prd_pkg::CountBits-1:0] cur_item_q, cur_item_d;
  logic [prd_pkg::CountBits-1:0] load_cnt;
  logic [15:0]                   byte_pos_q, byte_pos_d;
  logic [7:0]                    prev_q, prev_d;
  phase_e                        phase_q, phase_d;
  logic [prd_pkg::LenBits-1:0]   remain_q, remain_d;
  logic                          hdr_ok_q, hdr_ok_d;
  prd_pkg::prd_status_e          fstat_q, fstat_d;
  prd_pkg::prd_status_e          end_status;

  logic                          fire;
  logic                          frame_done;
  logic                          tbl_we;
  logic [prd_pkg::IdxBits-1:0]   tbl_addr;
  logic [prd_pkg::LenBits-1:0]   tbl_rd;
  logic [7:0]                    b;

  assign fire       = vld_q && room_i;
  assign frame_done = fire && item_q.cmd == prd_pkg::CMD_BYTE && item_q.frame_end;
  assign in_i.ready = !vld_q || fire;
  assign b          = item_q.resp_byte;
  assign tbl_rd     = table_q[cur_item_q[prd_pkg::IdxBits-1:0]];

  always_comb begin
    list_cnt_d = list_cnt_q;
    cur_item_d = cur_item_q;
    byte_pos_d = byte_pos_q;
    prev_d     = prev_q;
    phase_d    = phase_q;
    remain_d   = remain_q;
    hdr_ok_d   = hdr_ok_q;
    fstat_d    = fstat_q;
    end_status = prd_pkg::ST_OK;
    load_cnt   = item_q.new_list ? '0 : list_cnt_q;
    tbl_we     = 1'b0;
    tbl_addr   = load_cnt[prd_pkg::IdxBits-1:0];
    push_o     = '0;

    if (fire && item_q.cmd == prd_pkg::CMD_LOAD) begin
      list_cnt_d = load_cnt;
      if (load_cnt < prd_pkg::CountBits'(prd_pkg::MaxItems)) begin
        tbl_we     = 1'b1;
        list_cnt_d = load_cnt + prd_pkg::CountBits'(1);
      end
    end else if (fire) begin
      if (byte_pos_q == prd_pkg::HdrPos) begin
        hdr_ok_d = (b == 8'(list_cnt_q));
        prev_d   = '0;
      end else if (byte_pos_q > prd_pkg::HdrPos && hdr_ok_q && fstat_q == prd_pkg::ST_OK) begin
        case (phase_q)
          PH_SCAN: begin
            if (prev_q == prd_pkg::MarkerHi && b == prd_pkg::MarkerLo) begin
              if (cur_item_q >= list_cnt_q ||
                  cur_item_q >= prd_pkg::CountBits'(prd_pkg::MaxItems)) begin
                fstat_d = prd_pkg::ST_TOO_MANY;
              end else begin
                remain_d = tbl_rd;
                phase_d  = PH_LEN_HI;
              end
            end else if (prev_q == prd_pkg::RangeHi && b == prd_pkg::RangeLo) begin
              fstat_d = prd_pkg::ST_RANGE_ERR;
            end
            prev_d = b;
          end
          PH_LEN_HI: begin
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (remain_q == '0) begin
              cur_item_d = cur_item_q + prd_pkg::CountBits'(1);
              phase_d    = PH_SCAN;
              prev_d     = '0;
            end else begin
              phase_d = PH_DATA;
            end
          end
          default: begin
            push_o.num                = 2'd1;
            push_o.res[0].kind        = prd_pkg::KIND_DATA;
            push_o.res[0].data_out    = b;
            push_o.res[0].item_index  = 5'(cur_item_q);
            push_o.res[0].status      = prd_pkg::ST_OK;
            push_o.res[0].last        = 1'b0;
            remain_d                  = remain_q - prd_pkg::LenBits'(1);
            if (remain_q == prd_pkg::LenBits'(1)) begin
              cur_item_d = cur_item_q + prd_pkg::CountBits'(1);
              phase_d    = PH_SCAN;
              prev_d     = '0;
            end
          end
        endcase
      end

      if (byte_pos_q != 16'hFFFF) begin
        byte_pos_d = byte_pos_q + 16'd1;
      end

      if (frame_done) begin
        end_status = hdr_ok_d ? fstat_d : prd_pkg::ST_HDR_ERR;
        // The status result goes behind a data byte from the same transaction.
        push_o.res[push_o.num[0]] = '{kind:       prd_pkg::KIND_STATUS,
                                      data_out:   8'd0,
                                      item_index: 5'd0,
                                      status:     end_status,
                                      last:       1'b1};
        push_o.num = push_o.num + 2'd1;
        cur_item_d = '0;
        byte_pos_d = '0;
        prev_d     = '0;
        phase_d    = PH_SCAN;
        remain_d   = '0;
        hdr_ok_d   = 1'b0;
        fstat_d    = prd_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      item_q <= '{cmd:       in_i.cmd,
                  resp_byte: in_i.resp_byte,
                  item_len:  in_i.item_len,
                  new_list:  in_i.new_list,
                  frame_end: in_i.frame_end};
    end
    if (tbl_we) begin
      table_q[tbl_addr] <= prd_pkg::LenBits'(item_q.item_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      list_cnt_q <= '0;
      cur_item_q <= '0;
      byte_pos_q <= '0;
      prev_q     <= '0;
      phase_q    <= PH_SCAN;
      remain_q   <= '0;
      hdr_ok_q   <= 1'b0;
      fstat_q    <= prd_pkg::ST_OK;
    end else begin
      if (in_i.ready) begin
        vld_q <= in_i.valid;
      end
      list_cnt_q <= list_cnt_d;
      cur_item_q <= cur_item_d;
      byte_pos_q <= byte_pos_d;
      prev_q     <= prev_d;
      phase_q    <= phase_d;
      remain_q   <= remain_d;
      hdr_ok_q   <= hdr_ok_d;
      fstat_q    <= fstat_d;
    end
  end

  `PRD_ASSERT_NEXT(a_frame_clear, clk_i, rst_ni, frame_done, byte_pos_q == '0 && phase_q == PH_SCAN)
  `PRD_ASSERT_IMPL(a_data_remain, clk_i, rst_ni, phase_q == PH_DATA, remain_q != '0)
  `PRD_ASSERT_IMPL(a_hdr_scan, clk_i, rst_ni, !hdr_ok_q, phase_q == PH_SCAN && cur_item_q == '0)

endmodule

FILE: hdl/plc_read_response_deframer.sv
// Deframer for a PLC read-variables reply. Load the expected byte length of
// each requested item first (cmd 0, new_list starts a fresh list), then stream
// the reply one byte per transaction (cmd 1, frame_end on the last byte). Data
// bytes of each item come out tagged with the item index, and every frame
// closes with one status result (last set). The block takes one input
// transaction per cycle while the result queue has room; an accepted
// transaction is held in an input register until the queue has room, and
// its results are then written into the result queue. A byte may cause two
// results (its data byte and the frame status), and the output drains one
// result per cycle while ready is high through a four-entry result queue,
// so input accepts pause while the queue holds more than two results.
module plc_read_response_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  prd_in_if.sink    in_i,
  prd_out_if.source out_o
);

  prd_pkg::prd_push_t push;
  logic               room;

  prd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  prd_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

FILE: sim/plc_read_response_deframer_tb.sv
`timescale 1ns / 100ps

module plc_read_response_deframer_tb;

  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 120;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA
  } scan_phase_e;

  class deframer_scoreboard;
    logic [prd_pkg::LenBits-1:0]   len_tbl [prd_pkg::MaxItems];
    logic [prd_pkg::CountBits-1:0] list_cnt;
    logic [15:0]                   byte_pos;
    logic [7:0]                    prev_byte;
    scan_phase_e                   phase;
    logic [prd_pkg::LenBits-1:0]   remaining;
    logic [prd_pkg::CountBits-1:0] cur_item;
    logic                          hdr_ok;
    prd_pkg::prd_status_e          frm_status;

    prd_pkg::prd_result_t due_results[$];
    int failures;
    int data_seen;
    int status_seen [4];

    function void clear_frame();
      byte_pos   = '0;
      prev_byte  = '0;
      phase      = PH_SCAN;
      remaining  = '0;
      cur_item   = '0;
      hdr_ok     = 1'b0;
      frm_status = prd_pkg::ST_OK;
    endfunction

    function void reset_state();
      list_cnt = '0;
      clear_frame();
    endfunction

    function void item_finished();
      cur_item++;
      phase     = PH_SCAN;
      prev_byte = '0;
    endfunction

    function void push_result(logic kind, logic [7:0] data, logic [4:0] idx,
                              prd_pkg::prd_status_e st);
      prd_pkg::prd_result_t r;
      r.kind       = kind;
      r.data_out   = data;
      r.item_index = idx;
      r.status     = st;
      r.last       = kind;
      due_results.push_back(r);
    endfunction

    // Works out the results of one accepted transaction and queues them.
    function void deframe_item(prd_pkg::prd_item_t it);
      if (it.cmd == prd_pkg::CMD_LOAD) begin
        if (it.new_list) list_cnt = '0;
        if (list_cnt < prd_pkg::MaxItems) begin
          len_tbl[list_cnt[prd_pkg::IdxBits-1:0]] = it.item_len[prd_pkg::LenBits-1:0];
          list_cnt++;
        end
        return;
      end

      if (byte_pos == prd_pkg::HdrPos) begin
        hdr_ok    = (it.resp_byte == 8'(list_cnt));
        prev_byte = '0;
      end else if (byte_pos > prd_pkg::HdrPos && hdr_ok && frm_status == prd_pkg::ST_OK) begin
        case (phase)
          PH_SCAN: begin
            if (prev_byte == prd_pkg::MarkerHi && it.resp_byte == prd_pkg::MarkerLo) begin
              if (cur_item >= list_cnt || cur_item >= prd_pkg::MaxItems) begin
                frm_status = prd_pkg::ST_TOO_MANY;
              end else begin
                remaining = len_tbl[cur_item[prd_pkg::IdxBits-1:0]];
                phase     = PH_LEN_HI;
              end
            end else if (prev_byte == prd_pkg::RangeHi && it.resp_byte == prd_pkg::RangeLo) begin
              frm_status = prd_pkg::ST_RANGE_ERR;
            end
            prev_byte = it.resp_byte;
          end
          PH_LEN_HI: phase = PH_LEN_LO;
          PH_LEN_LO: begin
            if (remaining == '0) item_finished();
            else phase = PH_DATA;
          end
          default: begin
            push_result(prd_pkg::KIND_DATA, it.resp_byte, cur_item[4:0], prd_pkg::ST_OK);
            remaining--;
            if (remaining == '0) item_finished();
          end
        endcase
      end

      if (byte_pos != 16'hFFFF) byte_pos++;

      if (it.frame_end) begin
        push_result(prd_pkg::KIND_STATUS, 8'h00, 5'd0,
                    hdr_ok ? frm_status : prd_pkg::ST_HDR_ERR);
        clear_frame();
      end
    endfunction

    function void check_result(prd_pkg::prd_result_t got);
      prd_pkg::prd_result_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: kind %0d data %02h item %0d status %0d last %0d",
                   got.kind, got.data_out, got.item_index, got.status, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.kind == prd_pkg::KIND_DATA) data_seen++;
      else status_seen[got.status]++;
      if (got.kind !== want.kind || got.data_out !== want.data_out ||
          got.item_index !== want.item_index || got.status !== want.status ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("Mismatch: expected kind %0d data %02h item %0d status %0d last %0d",
                   want.kind, want.data_out, want.item_index, want.status, want.last);
          $display("          got      kind %0d data %02h item %0d status %0d last %0d",
                   got.kind, got.data_out, got.item_index, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  prd_in_if  in_if ();
  prd_out_if out_if ();

  plc_read_response_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  deframer_scoreboard sb;
  prd_pkg::prd_item_t frame_q[$];
  int                 list_lens[$];
  int                 items_sent;
  bit                 tx_idle;
  bit                 rx_idle;
  bit                 hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timed out waiting for the block.");
    $display("plc_read_response_deframer test failed");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid && out_if.ready)
      sb.check_result({out_if.kind, out_if.data_out, out_if.item_index,
                       out_if.status, out_if.last});
  end

  function automatic logic [7:0] safe_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = prd_pkg::MarkerLo;
      1: b = prd_pkg::RangeLo;
      default: begin
        b = 8'($urandom);
        if (b == prd_pkg::MarkerHi || b == prd_pkg::RangeHi) b = 8'h11;
      end
    endcase
    return b;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    prd_pkg::prd_item_t it;
    it.cmd       = prd_pkg::CMD_BYTE;
    it.resp_byte = b;
    it.item_len  = 16'($urandom);
    it.new_list  = 1'($urandom);
    it.frame_end = 1'b0;
    frame_q.push_back(it);
  endfunction

  // The length list is mirrored here so that frames can be built to match it.
  function automatic void put_load(logic [15:0] len, logic fresh);
    prd_pkg::prd_item_t it;
    it.cmd       = prd_pkg::CMD_LOAD;
    it.resp_byte = 8'($urandom);
    it.item_len  = len;
    it.new_list  = fresh;
    it.frame_end = 1'($urandom);
    frame_q.push_back(it);
    if (fresh) list_lens.delete();
    if (list_lens.size() < prd_pkg::MaxItems) list_lens.push_back(int'(len));
  endfunction

  function automatic void put_header(logic [7:0] count);
    repeat (20) put_byte(8'($urandom));
    put_byte(count);
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(0, 2)) put_byte(safe_byte());
  endfunction

  function automatic void put_item(int n_data);
    put_byte(prd_pkg::MarkerHi);
    put_byte(prd_pkg::MarkerLo);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    repeat (n_data) put_byte(8'($urandom));
  endfunction

  function automatic void close_frame();
    if (frame_q.size() == 0 || frame_q[frame_q.size() - 1].cmd != prd_pkg::CMD_BYTE)
      put_byte(safe_byte());
    frame_q[frame_q.size() - 1].frame_end = 1'b1;
  endfunction

  task automatic send_item(prd_pkg::prd_item_t it);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= it.cmd;
    in_if.resp_byte <= it.resp_byte;
    in_if.item_len  <= it.item_len;
    in_if.new_list  <= it.new_list;
    in_if.frame_end <= it.frame_end;
    do @(posedge clk); while (!in_if.ready);
    sb.deframe_item(it);
    items_sent++;
  endtask

  // Valid stays up after the last transaction; the next send or a drain
  // takes it over in the same time step.
  task automatic send_queue();
    foreach (frame_q[i]) send_item(frame_q[i]);
    frame_q.delete();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly well-formed replies to the current list, some broken on purpose.
  task automatic random_frame();
    int         lens[$];
    int         shape;
    int         n;
    int         cut;
    logic [7:0] count;
    shape = $urandom_range(0, 15);
    if (list_lens.size() == 0 || $urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 33) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0) put_load(16'($urandom), i == 0);
        else put_load(16'($urandom_range(0, 5)), i == 0);
      end
    end
    if (shape == 14) begin
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
      close_frame();
      send_queue();
      return;
    end
    lens  = list_lens;
    count = 8'(lens.size());
    if (shape == 11) count = count + 8'($urandom_range(1, 255));
    put_header(count);
    cut = (shape == 12) ? $urandom_range(0, lens.size()) : -1;
    foreach (lens[i]) begin
      put_noise();
      if (i == cut) begin
        put_byte(prd_pkg::RangeHi);
        put_byte(prd_pkg::RangeLo);
        put_noise();
      end
      if ($urandom_range(0, 19) == 0)
        put_load(16'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
      if (lens[i] > 8) begin
        put_item($urandom_range(0, 8));
        break;
      end
      put_item(lens[i]);
    end
    if (cut == lens.size()) begin
      put_byte(prd_pkg::RangeHi);
      put_byte(prd_pkg::RangeLo);
    end
    if (shape == 13) begin
      put_noise();
      put_item($urandom_range(0, 3));
    end else if (shape == 15) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      put_byte(prd_pkg::MarkerHi);
      put_byte(prd_pkg::MarkerLo);
      put_byte(8'($urandom));
    end
    close_frame();
    send_queue();
  endtask

  initial begin
    int          mark;
    bit          mid_hold_done;
    logic [15:0] len;

    sb = new;
    sb.reset_state();
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_req = 1'b0;
    mid_hold_done = 1'b0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= prd_pkg::CMD_LOAD;
    in_if.resp_byte <= '0;
    in_if.item_len  <= '0;
    in_if.new_list  <= 1'b0;
    in_if.frame_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing loaded yet: a marker finds no item to belong to.
    put_header(8'd0);
    put_item(0);
    close_frame();
    send_queue();

    // Empty, one-byte and three-byte items. Bytes that end a length or data
    // field must not pair with the next byte into a marker or a range stop.
    put_load(16'h0000, 1'b1);
    put_load(16'h0001, 1'b0);
    put_load(16'h0003, 1'b0);
    put_header(8'd3);
    put_byte(prd_pkg::MarkerLo);
    put_byte(prd_pkg::MarkerHi); put_byte(prd_pkg::MarkerLo); put_byte(8'h00);
    put_byte(prd_pkg::MarkerHi);
    put_byte(prd_pkg::MarkerLo);
    put_byte(prd_pkg::MarkerHi); put_byte(prd_pkg::MarkerLo); put_byte(8'h00);
    put_byte(8'h01);
    put_byte(prd_pkg::MarkerHi);
    put_byte(prd_pkg::MarkerLo);
    put_byte(prd_pkg::MarkerHi); put_byte(prd_pkg::MarkerLo); put_byte(8'h00);
    put_byte(8'h03);
    put_byte(8'h80); put_byte(8'h7F); put_byte(prd_pkg::RangeHi);
    put_byte(prd_pkg::RangeLo);
    close_frame();
    send_queue();

    // The frame ends on a data byte, so one transaction yields two results.
    put_header(8'd3);
    put_noise();
    put_item(0);
    put_item(1);
    put_item(3);
    close_frame();
    send_queue();

    // Wrong item count in the header.
    put_header(8'd2);
    put_item(0);
    put_item(1);
    close_frame();
    send_queue();

    // Frames too short to reach the header, and one that ends on it.
    put_byte(8'($urandom));
    close_frame();
    send_queue();
    repeat (20) put_byte(8'($urandom));
    close_frame();
    send_queue();
    put_header(8'd3);
    close_frame();
    send_queue();
    wait_drained();

    // Range stop after two items; what follows is ignored.
    put_header(8'd3);
    put_item(0);
    put_item(1);
    put_byte(prd_pkg::RangeHi);
    put_byte(prd_pkg::RangeLo);
    put_item(3);
    close_frame();
    send_queue();

    // One marker more than there are items.
    put_load(16'd1, 1'b1);
    put_load(16'd2, 1'b0);
    put_header(8'd2);
    put_item(1);
    put_item(2);
    put_noise();
    put_item(2);
    close_frame();
    send_queue();

    // Frames that stop inside a length field and inside a data field.
    put_header(8'd2);
    put_byte(prd_pkg::MarkerHi);
    put_byte(prd_pkg::MarkerLo);
    put_byte(8'h00);
    close_frame();
    send_queue();
    put_header(8'd2);
    put_item(1);
    put_item(1);
    close_frame();
    send_queue();

    // Loads in the middle of a frame take effect at once.
    put_header(8'd2);
    put_item(1);
    put_load(16'd4, 1'b1);
    put_item(4);
    close_frame();
    send_queue();
    put_load(16'd2, 1'b1);
    put_header(8'd1);
    put_item(2);
    put_load(16'd3, 1'b0);
    put_item(3);
    close_frame();
    send_queue();

    // Full list with the extreme lengths; the 33rd load is dropped.
    for (int i = 0; i < 33; i++) begin
      if (i < 30) len = 16'(i % 3);
      else if (i == 30) len = 16'h0000;
      else if (i == 31) len = 16'hFFFF;
      else len = 16'h5A5A;
      put_load(len, i == 0);
    end
    put_header(8'd32);
    for (int i = 0; i < 31; i++) put_item(i % 3);
    put_item(4);
    close_frame();
    send_queue();

    // Every one of the 32 items used, then one marker too many.
    for (int i = 0; i < 32; i++) put_load(16'(i % 4), i == 0);
    put_header(8'd32);
    for (int i = 0; i < 32; i++) put_item(i % 4);
    put_item(1);
    close_frame();
    send_queue();
    wait_drained();

    // Long output stall while the input keeps offering data bytes.
    put_load(16'd10, 1'b1);
    put_load(16'd12, 1'b0);
    put_header(8'd2);
    put_item(10);
    put_item(12);
    close_frame();
    hold_req = 1'b1;
    send_queue();
    wait_drained();

    mark = items_sent;
    while (items_sent - mark < 350) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (!mid_hold_done && items_sent - mark > 150) begin
        hold_req      = 1'b1;
        mid_hold_done = 1'b1;
      end
      random_frame();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    mark = items_sent;
    while (items_sent - mark < 150) random_frame();

    wait_drained();
    $display("Sent %0d input transactions in directed and random frames.", items_sent);
    $display("Checked %0d data bytes and %0d frame ends (ok %0d, header %0d, range %0d, %s %0d).",
             sb.data_seen, sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2] +
             sb.status_seen[3], sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             "too many", sb.status_seen[3]);
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("plc_read_response_deframer test passed");
    end else begin
      $display("%0d failures, %0d results never arrived.", sb.failures,
               sb.due_results.size());
      $display("plc_read_response_deframer test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/prd_pkg.sv
hdl/prd_in_if.sv
hdl/prd_out_if.sv
hdl/prd_result_fifo.sv
hdl/prd_parser.sv
hdl/plc_read_response_deframer.sv
sim/plc_read_response_deframer_tb.sv
